// ----- hdl/plee_pkg.sv -----
`timescale 1ns / 1ps
package plee_pkg;

	localparam int MODE_W  = 4;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 16;
	localparam int STAT_W  = 3;
	localparam int MAX_RESULTS = 16;

	localparam logic [MODE_W-1:0] MODE_APPEND  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PREPEND = 4'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_RM_HEAD = 4'd4;
	localparam logic [MODE_W-1:0] MODE_RM_TAIL = 4'd5;
	localparam logic [MODE_W-1:0] MODE_RM_AT   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SEARCH  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_READ    = 4'd8;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic              vld;
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  pos;
		logic              last;
	} res_t;

endpackage

// ----- hdl/plee_mem.sv -----
`timescale 1ns / 1ps
module plee_mem #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(CAPACITY)-1:0]   waddr,
	input  logic [plee_pkg::VAL_W-1:0]    wdata,
	input  logic [$clog2(CAPACITY)-1:0]   raddr,
	output logic [plee_pkg::VAL_W-1:0]    rdata
);
	import plee_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/plee_ctl.sv -----
`timescale 1ns / 1ps
module plee_ctl #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [plee_pkg::MODE_W-1:0]          mode,
	input  logic [plee_pkg::POS_W-1:0]           position,
	input  logic [plee_pkg::VAL_W-1:0]           value,
	output logic                                 busy,
	output logic [$clog2(CAPACITY+1)-1:0]        count,
	output plee_pkg::res_t                       res,
	output logic                                 mem_we,
	output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
	output logic [plee_pkg::VAL_W-1:0]           mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
	input  logic [plee_pkg::VAL_W-1:0]           mem_rdata
);
	import plee_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_INS      = 4'd1;
	localparam logic [3:0] S_INS_WR   = 4'd2;
	localparam logic [3:0] S_REM_V    = 4'd3;
	localparam logic [3:0] S_REM      = 4'd4;
	localparam logic [3:0] S_REM_WR   = 4'd5;
	localparam logic [3:0] S_SRCH     = 4'd6;
	localparam logic [3:0] S_SRCH_CMP = 4'd7;
	localparam logic [3:0] S_RD       = 4'd8;
	localparam logic [3:0] S_RD_OUT   = 4'd9;
	localparam logic [3:0] S_REV      = 4'd10;
	localparam logic [3:0] S_REV_A    = 4'd11;
	localparam logic [3:0] S_REV_B    = 4'd12;
	localparam logic [3:0] S_REV_W    = 4'd13;

	logic [3:0]       state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    ptr_q, ptr_d;
	logic [CW-1:0]    end_q, end_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [VAL_W-1:0] tmp_q, tmp_d;
	logic [POS_W-1:0] pos_q, pos_d;

	logic [POS_W-1:0] cnt7;
	logic [POS_W-1:0] at7;
	logic [POS_W-1:0] n7;
	logic [CW-1:0]    idx;
	logic [CW-1:0]    ptr_inc;
	logic [CW-1:0]    ptr_dec;

	// shared step unit for the walking pointer
	assign ptr_inc = ptr_q + 1'b1;
	assign ptr_dec = ptr_q - 1'b1;
	assign cnt7    = POS_W'(cnt_q);
	assign n7      = (cnt7 < POS_W'(MAX_RESULTS)) ? cnt7 : POS_W'(MAX_RESULTS);

	always_comb begin
		if (mode == MODE_APPEND || (mode == MODE_INSERT && position > cnt7)) begin
			idx = cnt_q;
		end else if (mode == MODE_PREPEND || position <= 7'd1) begin
			idx = '0;
		end else begin
			idx = CW'(position - 7'd1);
		end
		case (mode)
			MODE_RM_HEAD: at7 = 7'd1;
			MODE_RM_TAIL: at7 = cnt7;
			default:      at7 = position;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		end_d     = end_q;
		val_d     = val_q;
		tmp_d     = tmp_q;
		pos_d     = pos_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = val_q;
		mem_raddr = ptr_q[AW-1:0];
		res       = '0;
		res.last  = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					val_d = value;
					case (mode)
						MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								res.vld    = 1'b1;
								res.status = ST_FULL;
							end else begin
								ptr_d   = cnt_q;
								end_d   = idx;
								state_d = S_INS;
							end
						end
						MODE_UPDATE: begin
							res.vld = 1'b1;
							if (position == 7'd0 || position > cnt7) begin
								res.status = ST_BADPOS;
							end else begin
								mem_we     = 1'b1;
								mem_waddr  = AW'(position - 7'd1);
								mem_wdata  = value;
								res.status = ST_OK;
							end
						end
						MODE_RM_HEAD, MODE_RM_TAIL, MODE_RM_AT: begin
							if (cnt_q == '0) begin
								res.vld    = 1'b1;
								res.status = ST_EMPTY;
							end else if (at7 == 7'd0 || at7 > cnt7) begin
								res.vld    = 1'b1;
								res.status = ST_BADPOS;
							end else begin
								pos_d     = at7;
								ptr_d     = CW'(at7 - 7'd1);
								mem_raddr = AW'(at7 - 7'd1);
								state_d   = S_REM_V;
							end
						end
						MODE_SEARCH: begin
							if (cnt_q == '0) begin
								res.vld    = 1'b1;
								res.status = ST_NOTFOUND;
							end else begin
								ptr_d   = '0;
								state_d = S_SRCH;
							end
						end
						MODE_READ: begin
							if (cnt_q == '0) begin
								res.vld    = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								ptr_d   = '0;
								end_d   = CW'(n7);
								state_d = S_RD;
							end
						end
						MODE_REVERSE: begin
							ptr_d   = '0;
							end_d   = cnt_q - 1'b1;
							state_d = S_REV;
						end
						default: begin
							res.vld    = 1'b1;
							res.status = ST_OK;
						end
					endcase
				end
			end
			// insert: move entries back one slot from the tail down to idx
			S_INS: begin
				if (ptr_q == end_q) begin
					mem_we     = 1'b1;
					mem_waddr  = ptr_q[AW-1:0];
					mem_wdata  = val_q;
					cnt_d      = cnt_q + 1'b1;
					res.vld    = 1'b1;
					res.status = ST_OK;
					state_d    = S_IDLE;
				end else begin
					mem_raddr = ptr_dec[AW-1:0];
					state_d   = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wdata = mem_rdata;
				ptr_d     = ptr_dec;
				state_d   = S_INS;
			end
			S_REM_V: begin
				tmp_d   = mem_rdata;
				state_d = S_REM;
			end
			// remove: pull later entries forward one slot
			S_REM: begin
				if (ptr_inc == cnt_q) begin
					cnt_d      = cnt_q - 1'b1;
					res.vld    = 1'b1;
					res.status = ST_OK;
					res.value  = tmp_q;
					res.pos    = pos_q;
					state_d    = S_IDLE;
				end else begin
					mem_raddr = ptr_inc[AW-1:0];
					state_d   = S_REM_WR;
				end
			end
			S_REM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wdata = mem_rdata;
				ptr_d     = ptr_inc;
				state_d   = S_REM;
			end
			S_SRCH: begin
				mem_raddr = ptr_q[AW-1:0];
				state_d   = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (mem_rdata == val_q) begin
					res.vld    = 1'b1;
					res.status = ST_OK;
					res.value  = val_q;
					res.pos    = POS_W'(ptr_inc);
					state_d    = S_IDLE;
				end else if (ptr_inc == cnt_q) begin
					res.vld    = 1'b1;
					res.status = ST_NOTFOUND;
					state_d    = S_IDLE;
				end else begin
					ptr_d   = ptr_inc;
					state_d = S_SRCH;
				end
			end
			S_RD: begin
				mem_raddr = ptr_q[AW-1:0];
				state_d   = S_RD_OUT;
			end
			S_RD_OUT: begin
				res.vld    = 1'b1;
				res.status = ST_OK;
				res.value  = mem_rdata;
				res.pos    = POS_W'(ptr_inc);
				res.last   = (ptr_inc == end_q);
				if (ptr_inc == end_q) begin
					state_d = S_IDLE;
				end else begin
					ptr_d   = ptr_inc;
					state_d = S_RD;
				end
			end
			// reverse: swap the entries at the head/tail pointers until they meet
			S_REV: begin
				if (cnt_q > CW'(1) && ptr_q < end_q) begin
					mem_raddr = ptr_q[AW-1:0];
					state_d   = S_REV_A;
				end else begin
					res.vld    = 1'b1;
					res.status = ST_OK;
					state_d    = S_IDLE;
				end
			end
			S_REV_A: begin
				tmp_d     = mem_rdata;
				mem_raddr = end_q[AW-1:0];
				state_d   = S_REV_B;
			end
			S_REV_B: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wdata = mem_rdata;
				state_d   = S_REV_W;
			end
			S_REV_W: begin
				mem_we    = 1'b1;
				mem_waddr = end_q[AW-1:0];
				mem_wdata = tmp_q;
				ptr_d     = ptr_inc;
				end_d     = end_q - 1'b1;
				state_d   = S_REV;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		end_q <= end_d;
		val_q <= val_d;
		tmp_q <= tmp_d;
		pos_q <= pos_d;
	end

	assign busy  = (state_q != S_IDLE);
	assign count = cnt_q;

endmodule

// ----- hdl/positional_list_engine_unit.sv -----
`timescale 1ns / 1ps
// Errors, update and unused modes give their result in the cycle after start.
// Insert, remove, search, read-all and reverse step through the list entry by entry
// (list RAM with one read port and one write port).
// Throughput: one request at a time; busy stays high until the final result is out.
// Reset (arst_n low) clears the entry count; list contents stay undefined until written.
// Results are strobed for one cycle; the receiver cannot stall.
module positional_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [plee_pkg::MODE_W-1:0]        mode,
	input  logic [plee_pkg::POS_W-1:0]         position,
	input  logic [plee_pkg::VAL_W-1:0]         value,
	output logic                               strobe,
	output logic [plee_pkg::STAT_W-1:0]        status,
	output logic [plee_pkg::VAL_W-1:0]         item_value,
	output logic [plee_pkg::POS_W-1:0]         item_position,
	output logic [plee_pkg::POS_W-1:0]         entry_count,
	output logic                               last
);
	import plee_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	res_t             res;
	logic [CW-1:0]    cnt;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_rdata;

	logic              strobe_q;
	logic [STAT_W-1:0] status_q;
	logic [VAL_W-1:0]  value_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;

	plee_ctl #(.CAPACITY(CAPACITY)) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.position  (position),
		.value     (value),
		.busy      (busy),
		.count     (cnt),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	plee_mem #(.CAPACITY(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= res.status;
		value_q  <= res.value;
		pos_q    <= res.pos;
		last_q   <= res.last;
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign item_value    = value_q;
	assign item_position = pos_q;
	assign last          = last_q;
	// count already reflects the finished request when the strobe shows
	assign entry_count   = POS_W'(cnt);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= POS_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_FULL) |-> (entry_count == POS_W'(CAPACITY)))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_EMPTY) |-> (entry_count == 7'd0))
		else $error("empty status with entries held");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("busy after final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("idle in the middle of a read-out");

endmodule
